@@ rtl/core/fhcp_pkg.sv @@
// shared types, character codes and result codes for the framed hex command parser
package fhcp_pkg;

  // slots of the frame view seen by the decoder
  localparam int NUM_SLOTS = 8;
  // width of the stored character count
  localparam int CNT_W = 4;

  // framing characters
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  // filler for slots beyond the frame size, never a hex digit
  localparam logic [7:0] CH_NONE  = 8'h00;

  // hex digit ranges
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_HEX_LO = 8'h41;
  localparam logic [7:0] CH_HEX_HI = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  // command letter pairs
  localparam logic [15:0] CMD_IS = 16'h4953;
  localparam logic [15:0] CMD_GW = 16'h4757;
  localparam logic [15:0] CMD_SG = 16'h5347;
  localparam logic [15:0] CMD_SF = 16'h5346;

  // parameter limits
  localparam logic [7:0] GAIN_MAX = 8'h07;
  localparam logic [7:0] RATE_MAX = 8'h01;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_CMD   = 2'd2;
  localparam logic [1:0] ST_PARAM = 2'd3;

  // command kinds
  localparam logic [1:0] KIND_IS = 2'd0;
  localparam logic [1:0] KIND_GW = 2'd1;
  localparam logic [1:0] KIND_SG = 2'd2;
  localparam logic [1:0] KIND_SF = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       sensor_busy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  command_kind;
    logic [7:0]  param_byte;
    logic [15:0] param_word;
    logic        word_valid;
    logic        clear_busy;
  } out_item_t;

  // collected frame as handed to the decoder
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] chars;
    logic                      complete;
  } frame_view_t;

  // {valid, value} of one hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = c - HEX_ALPHA_OFS;
      if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
        return {1'b1, c[3:0]};
      end else if (c >= CH_HEX_LO && c <= CH_HEX_HI) begin
        return {1'b1, d[3:0]};
      end else begin
        return 5'b0;
      end
    end
  endfunction

endpackage

@@ rtl/core/fhcp_collect.sv @@
// frame collector: character count, overflow mark and character store
module fhcp_collect #(
  parameter int FRAME_CHARS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output fhcp_pkg::frame_view_t view
);
  import fhcp_pkg::*;

  localparam int IDX_W = $clog2(FRAME_CHARS);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_CHARS);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       store_r [FRAME_CHARS];
  logic             is_delim;
  logic             wr_en;

  assign is_delim = (rx_byte == CH_OPEN) || (rx_byte == CH_CLOSE);
  assign wr_en    = step && !is_delim && (cnt_r < FULL);

  // count and overflow mark, both cleared by either delimiter
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (step) begin
      if (is_delim) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (cnt_r < FULL) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // character store, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[cnt_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  // slots beyond the frame size read as a non-hex filler
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_view
    if (i < FRAME_CHARS) begin : g_slot
      assign view.chars[i] = store_r[i];
    end else begin : g_none
      assign view.chars[i] = CH_NONE;
    end
  end

  assign view.complete = (cnt_r == FULL) && !ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL)
    else $error("character count beyond frame size");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n) ovf_r |-> cnt_r == FULL)
    else $error("overflow mark set with frame not full");
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_delim) |=> (cnt_r == '0 && !ovf_r))
    else $error("delimiter did not clear the frame");

endmodule

@@ rtl/core/fhcp_decode.sv @@
// frame decoder: framing check, command match, hex parameters and range checks
module fhcp_decode (
  input  fhcp_pkg::frame_view_t view,
  input  logic                  sensor_busy,
  output fhcp_pkg::out_item_t   result
);
  import fhcp_pkg::*;

  logic [4:0]  n0, n1, n2, n3;
  logic        byte_ok, word_ok;
  logic [7:0]  pbyte;
  logic [15:0] pword;
  logic [15:0] pair;

  // parameter characters sit in slots two to five
  assign n0 = hex_nibble(view.chars[2]);
  assign n1 = hex_nibble(view.chars[3]);
  assign n2 = hex_nibble(view.chars[4]);
  assign n3 = hex_nibble(view.chars[5]);

  assign byte_ok = n0[4] && n1[4];
  assign word_ok = byte_ok && n2[4] && n3[4];
  assign pbyte   = byte_ok ? {n0[3:0], n1[3:0]} : 8'h00;
  assign pword   = word_ok ? {n0[3:0], n1[3:0], n2[3:0], n3[3:0]} : 16'h0000;
  assign pair    = {view.chars[0], view.chars[1]};

  // result selection
  always_comb begin
    result = '0;
    if (!view.complete) begin
      result.status = ST_FRAME;
    end else begin
      result.param_byte = pbyte;
      result.param_word = pword;
      result.word_valid = word_ok;
      if (pair == CMD_IS) begin
        result.command_kind = KIND_IS;
        result.clear_busy   = 1'b1;
      end else if (pair == CMD_GW && !sensor_busy) begin
        result.command_kind = KIND_GW;
        if (!byte_ok) result.status = ST_PARAM;
      end else if (pair == CMD_SG && !sensor_busy) begin
        result.command_kind = KIND_SG;
        if (!byte_ok || pbyte > GAIN_MAX) result.status = ST_PARAM;
      end else if (pair == CMD_SF && !sensor_busy) begin
        result.command_kind = KIND_SF;
        if (!byte_ok || pbyte > RATE_MAX) result.status = ST_PARAM;
      end else begin
        result.status = ST_CMD;
      end
    end
  end

endmodule

@@ rtl/core/framed_hex_command_parser.sv @@
// top level of the framed hex command parser: input register, collector, decoder, result register
//
//   channel  direction  handshake            beat payload
//   in_      input      in_valid / in_stall  in_data  (rx_byte, sensor_busy)
//   out_     output     out_valid/out_stall  out_data (status, kind, params, flags)
//
// one byte per cycle sustained while no closing byte is stalled; each byte is held in the input register and
// the result of a closing byte is loaded into the result register as that byte moves on.
// reset clears valid flags, count and overflow mark; the character store is not reset.
// a waiting result stalls the input only when the next byte is another ')'.
module framed_hex_command_parser #(
  parameter int FRAME_CHARS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fhcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fhcp_pkg::out_item_t out_data
);
  import fhcp_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  logic        in_take;
  logic        is_close;
  logic        out_free;
  logic        fire;
  logic        load_out;
  frame_view_t view;
  out_item_t   result;

  assign is_close = in_item_r.rx_byte == CH_CLOSE;
  assign out_free = !out_valid_r || !out_stall;
  // the registered byte moves on unless it is a close and the result slot is held
  assign fire     = in_valid_r && (!is_close || out_free);
  assign load_out = fire && is_close;
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  fhcp_collect #(
    .FRAME_CHARS(FRAME_CHARS)
  ) u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .rx_byte (in_item_r.rx_byte),
    .view    (view)
  );

  fhcp_decode u_decode (
    .view        (view),
    .sensor_busy (in_item_r.sensor_busy),
    .result      (result)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_close_result: assert property (@(posedge clk) disable iff (!rst_n) load_out |=> out_valid)
    else $error("closing byte gave no result beat");
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && is_close && out_valid_r && out_stall))
    else $error("input stalled without a held result");
  a_clear_is: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clear_busy) |->
      (out_data.status == ST_OK && out_data.command_kind == KIND_IS))
    else $error("clear_busy on a result other than an accepted init");
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FRAME) |->
      (out_data.param_word == 16'h0000 && !out_data.word_valid && !out_data.clear_busy))
    else $error("framing error result carries data");

endmodule

@@ tb/framed_hex_command_parser_tb.sv @@
// testbench for the framed hex command parser: directed frames, random frames, scoreboard
module framed_hex_command_parser_tb;
  import fhcp_pkg::*;

  localparam int FRAME_LEN = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BURST_CYCLES = 400;

  // one row of the directed frame list
  typedef struct {
    string     text;
    logic      busy;
    bit        typed;
    out_item_t reply;
  } frame_row_t;

  // what the sender knows about each offered beat
  typedef struct {
    bit        typed;
    out_item_t reply;
  } beat_note_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // parser state as seen by the testbench
  logic [7:0] frame_chars [8];
  int         frame_count = 0;
  bit         frame_overflow = 1'b0;

  out_item_t  reply_q [$];
  beat_note_t beat_notes [$];
  frame_row_t directed_rows [$];

  int err_count = 0;
  int items_sent = 0;
  int send_pct = 38;
  int recv_pct = 56;
  int burst_req = 0;
  int burst_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  framed_hex_command_parser #(.FRAME_CHARS(FRAME_LEN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // value of an uppercase hex digit, -1 for anything else
  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_DIG_LO && c <= CH_DIG_HI) return int'(c) - int'(CH_DIG_LO);
    if (c >= CH_HEX_LO && c <= CH_HEX_HI) return int'(c) - int'(CH_HEX_LO) + 10;
    return -1;
  endfunction

  // advance the parser state by one byte; returns 1 when a reply is produced
  function automatic bit parse_byte(input in_item_t b, output out_item_t r);
    int          nib [4];
    bit          byte_ok;
    bit          word_ok;
    logic [15:0] cmd;
    r = '0;
    if (b.rx_byte == CH_OPEN) begin
      frame_count = 0;
      frame_overflow = 1'b0;
      return 1'b0;
    end
    if (b.rx_byte != CH_CLOSE) begin
      if (frame_count >= FRAME_LEN) begin
        frame_overflow = 1'b1;
      end else begin
        frame_chars[frame_count] = b.rx_byte;
        frame_count++;
      end
      return 1'b0;
    end
    // closing byte: framing check first, then command and parameters
    if (frame_count != FRAME_LEN || frame_overflow) begin
      r.status = ST_FRAME;
    end else begin
      for (int i = 0; i < 4; i++) begin
        nib[i] = (2 + i < FRAME_LEN) ? hex_value(frame_chars[2 + i]) : -1;
      end
      byte_ok = nib[0] >= 0 && nib[1] >= 0;
      word_ok = byte_ok && nib[2] >= 0 && nib[3] >= 0;
      if (byte_ok) r.param_byte = 8'(nib[0] * 16 + nib[1]);
      if (word_ok) begin
        r.param_word = {r.param_byte, 8'(nib[2] * 16 + nib[3])};
        r.word_valid = 1'b1;
      end
      cmd = {frame_chars[0], frame_chars[1]};
      r.status = ST_OK;
      if (cmd == CMD_IS) begin
        r.command_kind = KIND_IS;
        r.clear_busy = 1'b1;
      end else if (cmd == CMD_GW && !b.sensor_busy) begin
        r.command_kind = KIND_GW;
        if (!byte_ok) r.status = ST_PARAM;
      end else if (cmd == CMD_SG && !b.sensor_busy) begin
        r.command_kind = KIND_SG;
        if (!byte_ok || r.param_byte > GAIN_MAX) r.status = ST_PARAM;
      end else if (cmd == CMD_SF && !b.sensor_busy) begin
        r.command_kind = KIND_SF;
        if (!byte_ok || r.param_byte > RATE_MAX) r.status = ST_PARAM;
      end else begin
        r.status = ST_CMD;
        r.command_kind = KIND_IS;
      end
    end
    frame_count = 0;
    frame_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic out_item_t make_reply(input logic [1:0] st, input logic [1:0] kind,
                                           input logic [7:0] pb, input logic [15:0] pw,
                                           input logic wv, input logic cb);
    out_item_t r;
    r.status = st;
    r.command_kind = kind;
    r.param_byte = pb;
    r.param_word = pw;
    r.word_valid = wv;
    r.clear_busy = cb;
    return r;
  endfunction

  function automatic void add_row(input string text, input logic busy, input bit typed,
                                  input out_item_t reply);
    frame_row_t row;
    row.text = text;
    row.busy = busy;
    row.typed = typed;
    row.reply = reply;
    directed_rows.push_back(row);
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (err_count < 50) $display("error: %s got %0h want %0h", what, got, want);
    err_count++;
  endtask

  // offer one beat and hold it until it is taken
  task automatic send_byte(input logic [7:0] c, input logic busy, input bit typed,
                           input out_item_t reply);
    beat_note_t note;
    in_item_t   beat;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    note.typed = typed;
    note.reply = reply;
    beat_notes.push_back(note);
    beat.rx_byte = c;
    beat.sensor_busy = busy;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] c);
    send_byte(c, logic'($urandom_range(99) < 30), 1'b0, '0);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    return (v < 10) ? 8'(CH_DIG_LO + v) : 8'(CH_HEX_LO + v - 10);
  endfunction

  // any byte except the framing characters
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_OPEN || c == CH_CLOSE) c = 8'($urandom_range(255));
    return c;
  endfunction

  // mostly well-formed frames with random content, some broken frames and noise
  task automatic send_random_frame();
    int          mode;
    int          pick;
    int          len;
    logic [15:0] cmd;
    logic [7:0]  c;
    mode = $urandom_range(99);
    if (mode < 75) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1: cmd = CMD_IS;
        2, 3: cmd = CMD_GW;
        4, 5: cmd = CMD_SG;
        6, 7: cmd = CMD_SF;
        8: begin
          cmd = {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h41, 8'h5A))};
        end
        default: cmd = {body_byte(), body_byte()};
      endcase
      send_plain(CH_OPEN);
      send_plain(cmd[15:8]);
      send_plain(cmd[7:0]);
      for (int i = 0; i < 6; i++) begin
        pick = $urandom_range(99);
        if (i < 2 && pick < 40) c = (i == 0) ? CH_DIG_LO : hex_char($urandom_range(9));
        else if (pick < 80) c = hex_char($urandom_range(15));
        else if (pick < 92) c = 8'($urandom_range(8'h2A, 8'h7E));
        else c = body_byte();
        if (c == CH_OPEN || c == CH_CLOSE) c = CH_DIG_LO;
        send_plain(c);
      end
      send_plain(CH_CLOSE);
    end else if (mode < 90) begin
      // broken frame: random length, stray opens, random bytes
      len = $urandom_range(11);
      send_plain(CH_OPEN);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 5) send_plain(CH_OPEN);
        else if ($urandom_range(1)) send_plain(hex_char($urandom_range(15)));
        else send_plain(body_byte());
      end
      send_plain(CH_CLOSE);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_plain(8'($urandom_range(255)));
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (burst_req != burst_seen) begin
      burst_seen = burst_req;
      hold_left = BURST_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // scoreboard: predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin
    beat_note_t note;
    out_item_t  pred;
    out_item_t  want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        note.typed = 1'b0;
        note.reply = '0;
        if (beat_notes.size() != 0) note = beat_notes.pop_front();
        if (parse_byte(in_data, pred)) reply_q.push_back(note.typed ? note.reply : pred);
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report("result with nothing pending, status", 16'(out_data.status), 16'h0);
        end else begin
          want = reply_q.pop_front();
          if (out_data.status !== want.status)
            report("status", 16'(out_data.status), 16'(want.status));
          if (out_data.command_kind !== want.command_kind)
            report("command_kind", 16'(out_data.command_kind), 16'(want.command_kind));
          if (out_data.param_byte !== want.param_byte)
            report("param_byte", 16'(out_data.param_byte), 16'(want.param_byte));
          if (out_data.param_word !== want.param_word)
            report("param_word", out_data.param_word, want.param_word);
          if (out_data.word_valid !== want.word_valid)
            report("word_valid", 16'(out_data.word_valid), 16'(want.word_valid));
          if (out_data.clear_busy !== want.clear_busy)
            report("clear_busy", 16'(out_data.clear_busy), 16'(want.clear_busy));
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [7:0] c;
    frame_row_t row;
    // DEL in the text stands for a NUL byte
    add_row("(IS000000)", 1'b1, 1'b1,
            make_reply(ST_OK, KIND_IS, 8'h00, 16'h0000, 1'b1, 1'b1));
    add_row("(GWFFFF\377\377)", 1'b0, 1'b1,
            make_reply(ST_OK, KIND_GW, 8'hFF, 16'hFFFF, 1'b1, 1'b0));
    add_row("(GW12)", 1'b0, 1'b1,
            make_reply(ST_FRAME, KIND_IS, 8'h00, 16'h0000, 1'b0, 1'b0));
    add_row("(GW123456789)", 1'b0, 1'b1,
            make_reply(ST_FRAME, KIND_IS, 8'h00, 16'h0000, 1'b0, 1'b0));
    add_row("()", 1'b0, 1'b1,
            make_reply(ST_FRAME, KIND_IS, 8'h00, 16'h0000, 1'b0, 1'b0));
    add_row("(SG07ZZZZ)", 1'b0, 1'b0, '0);
    add_row("(SG08AB12)", 1'b0, 1'b0, '0);
    add_row("(SF01\177\177\177\177)", 1'b0, 1'b0, '0);
    add_row("(SF02C3D4)", 1'b0, 1'b0, '0);
    add_row("(SF00E5F6)", 1'b0, 1'b0, '0);
    add_row("(GW1A2B3C)", 1'b1, 1'b1,
            make_reply(ST_CMD, KIND_IS, 8'h1A, 16'h1A2B, 1'b1, 1'b0));
    add_row("(SG010000)", 1'b1, 1'b0, '0);
    add_row("(XY123456)", 1'b0, 1'b0, '0);
    add_row("(GWG00000)", 1'b0, 1'b0, '0);
    add_row("(GWab0000)", 1'b0, 1'b0, '0);
    add_row("(SG0/:@G`)", 1'b0, 1'b0, '0);
    add_row("IS9F9F9F)", 1'b1, 1'b0, '0);
    add_row("(GW12((IS0A0B0C)", 1'b0, 1'b0, '0);
    add_row("(123456789(SF0100FF)", 1'b0, 1'b0, '0);
    add_row("(1234567890)(SG070000)", 1'b0, 1'b0, '0);
    add_row("(IS5A5A5A)", 1'b0, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: directed frames, then random frames
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int i = 0; i < row.text.len(); i++) begin
        c = row.text[i];
        if (c == 8'h7F) c = 8'h00;
        send_byte(c, row.busy, row.typed && i == row.text.len() - 1, row.reply);
      end
    end
    while (items_sent < 450) send_random_frame();

    // phase two: idling swapped
    send_pct = 56;
    recv_pct = 38;
    while (items_sent < 900) send_random_frame();

    // phase three: no idling, with one long receiver hold-off
    send_pct = 0;
    recv_pct = 0;
    while (items_sent < 1000) send_random_frame();
    burst_req++;
    while (items_sent < 1350) send_random_frame();
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
